FILE: design/bfa_pkg.sv
// Shared types for the broadcast float add block.
// Used by the front end, the queue and the FP32 adder.
`timescale 1ns / 1ps

package bfa_pkg;

  typedef struct packed {
    logic [31:0] full_operand;
    logic [31:0] second_operand;
    logic        last_elem;
  } add_item_t;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_STREAM = 1'b1
  } req_type_e;

  typedef enum logic [7:0] {
    CFG_BROADCAST_ON = 8'd0,
    CFG_INNER_SIZE   = 8'd1,
    CFG_EXPAND_SIZE  = 8'd2,
    CFG_TOTAL_ELEMS  = 8'd3
  } cfg_index_e;

  localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;

endpackage

FILE: design/bfa_front.sv
// Front end: configuration registers, position counters, table index reduction
// and the operand table. Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [7:0]           cfg_index_i,
  input  logic [24:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [9:0]           table_index_i,
  input  logic [31:0]          table_value_i,
  input  logic [31:0]          full_operand_i,
  input  logic [31:0]          other_operand_i,
  output logic                 item_valid_o,
  output bfa_pkg::add_item_t   item_o,
  input  logic                 queue_full_i
);

  localparam int          IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int          K      = 24 + $clog2(TABLE_DEPTH);
  localparam logic [63:0] RECIP64 = (64'd1 << K) / TABLE_DEPTH;
  localparam logic [24:0] RECIP  = RECIP64[24:0];
  localparam logic [16:0] DV     = 17'(TABLE_DEPTH);

  typedef struct packed {
    logic        is_load;
    logic        use_tbl;
    logic [23:0] x;
    logic [31:0] tval;
    logic [31:0] full;
    logic [31:0] other;
    logic        last;
  } stage_t;

  logic        bcast_q;
  logic [24:0] inner_size_q, expand_size_q, total_q;
  logic [23:0] inner_q, expand_q, outer_q, elem_q;

  logic        fen, accept, stream;
  logic        last;
  logic        p0_v_q, p1_v_q, p2_v_q, p3_v_q, p4_v_q;
  stage_t      p0_q, p1_q, p2_q, p3_q, p4_q;
  logic [23:0] p1_qt_q;
  logic [24:0] p2_m_q;
  logic [48:0] prod;
  logic [40:0] prod2;
  logic [24:0] r, r_fix;
  logic [IW-1:0] idx;
  logic [IW-1:0] p3_idx_q;
  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rd_q;

  assign fen        = !p4_v_q || !queue_full_i;
  assign in_stall_o = !fen;
  assign accept     = in_valid_i && fen;
  assign stream     = req_type_i == bfa_pkg::REQ_STREAM;
  assign last       = ({1'b0, elem_q} + 25'd1) >= total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcast_q       <= 1'b0;
      inner_size_q  <= 25'd1;
      expand_size_q <= 25'd1;
      total_q       <= 25'd1;
      inner_q       <= '0;
      expand_q      <= '0;
      outer_q       <= '0;
      elem_q        <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bfa_pkg::CFG_BROADCAST_ON: bcast_q       <= cfg_data_i[0];
        bfa_pkg::CFG_INNER_SIZE:   inner_size_q  <= cfg_data_i;
        bfa_pkg::CFG_EXPAND_SIZE:  expand_size_q <= cfg_data_i;
        bfa_pkg::CFG_TOTAL_ELEMS:  total_q       <= cfg_data_i;
        default: ;
      endcase
      if (cfg_index_i <= bfa_pkg::CFG_TOTAL_ELEMS) begin
        inner_q  <= '0;
        expand_q <= '0;
        outer_q  <= '0;
        elem_q   <= '0;
      end
    end else if (accept && stream) begin
      if (last) begin
        inner_q  <= '0;
        expand_q <= '0;
        outer_q  <= '0;
        elem_q   <= '0;
      end else begin
        elem_q <= elem_q + 24'd1;
        if (({1'b0, inner_q} + 25'd1) >= inner_size_q) begin
          inner_q <= '0;
          if (({1'b0, expand_q} + 25'd1) >= expand_size_q) begin
            expand_q <= '0;
            outer_q  <= outer_q + inner_size_q[23:0];
          end else begin
            expand_q <= expand_q + 24'd1;
          end
        end else begin
          inner_q <= inner_q + 24'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
    end else if (fen) begin
      p0_v_q <= accept;
      p1_v_q <= p0_v_q;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q && !p3_q.is_load;
    end
  end

  assign prod  = 49'(p0_q.x) * 49'(RECIP);
  assign prod2 = 41'(p1_qt_q) * 41'(DV);
  assign r     = {1'b0, p2_q.x} - p2_m_q;
  assign r_fix = (r >= {8'd0, DV}) ? r - {8'd0, DV} : r;
  assign idx   = r_fix[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (fen) begin
      p0_q.is_load <= !stream;
      p0_q.use_tbl <= bcast_q;
      p0_q.x       <= stream ? (outer_q + inner_q) : {14'd0, table_index_i};
      p0_q.tval    <= table_value_i;
      p0_q.full    <= full_operand_i;
      p0_q.other   <= other_operand_i;
      p0_q.last    <= last;
      p1_q         <= p0_q;
      p1_qt_q      <= 24'(prod >> K);
      p2_q         <= p1_q;
      p2_m_q       <= prod2[24:0];
      p3_q         <= p2_q;
      p3_idx_q     <= idx;
      p4_q         <= p3_q;
      if (p3_v_q && p3_q.is_load) begin
        mem[p3_idx_q] <= p3_q.tval;
      end
      rd_q <= mem[p3_idx_q];
    end
  end

  assign item_valid_o          = p4_v_q;
  assign item_o.full_operand   = p4_q.full;
  assign item_o.second_operand = p4_q.use_tbl ? rd_q : p4_q.other;
  assign item_o.last_elem      = p4_q.last;

endmodule

FILE: design/bfa_queue.sv
// Two-entry queue between the front end and the adder.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bfa_pkg::add_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               not_empty_o,
  output bfa_pkg::add_item_t head_o
);

  bfa_pkg::add_item_t buf_q [2];
  logic               wr_q, rd_q;
  logic [1:0]         cnt_q;
  logic               do_push, do_pop;

  assign full_o      = cnt_q == 2'd2;
  assign not_empty_o = cnt_q != 2'd0;
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign head_o      = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_q] <= push_item_i;
  end

endmodule

FILE: design/bfa_fpadd.sv
// Three-stage IEEE binary32 adder, round to nearest even, with output register.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_fpadd (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bfa_pkg::add_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        sum_value_o,
  output logic               last_elem_o
);

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic en;
  logic a_v_q, b_v_q, o_v_q;

  logic [31:0] fa, fb, big, lesser;
  logic [7:0]  big_e, small_e, d;
  logic [23:0] big_m, small_m;
  logic [26:0] small_ext, sh, al;
  logic        st, nan_a, nan_b, inf_a, inf_b;

  logic        a_sign_q, a_sub_q, a_nan_q, a_inf_q, a_isign_q, a_last_q;
  logic [7:0]  a_e_q;
  logic [26:0] a_big_q, a_al_q;

  logic [27:0] sum;
  logic [4:0]  lz;
  logic [7:0]  lim, shl;
  logic [26:0] nm;
  logic [8:0]  ne;

  logic        b_sign_q, b_nan_q, b_inf_q, b_isign_q, b_last_q;
  logic [8:0]  b_e_q;
  logic [26:0] b_m_q;

  logic        up;
  logic [24:0] mr;
  logic [9:0]  ef;
  logic [22:0] frac;
  logic [31:0] res;

  logic [31:0] o_sum_q;
  logic        o_last_q;

  assign en    = !o_v_q || !out_stall_i;
  assign pop_o = en && in_valid_i;

  always_comb begin
    fa      = item_i.full_operand;
    fb      = item_i.second_operand;
    nan_a   = (fa[30:23] == 8'hFF) && (fa[22:0] != '0);
    nan_b   = (fb[30:23] == 8'hFF) && (fb[22:0] != '0);
    inf_a   = (fa[30:23] == 8'hFF) && (fa[22:0] == '0);
    inf_b   = (fb[30:23] == 8'hFF) && (fb[22:0] == '0);
    big     = (fa[30:0] >= fb[30:0]) ? fa : fb;
    lesser  = (fa[30:0] >= fb[30:0]) ? fb : fa;
    big_e   = (big[30:23] == '0) ? 8'd1 : big[30:23];
    small_e = (lesser[30:23] == '0) ? 8'd1 : lesser[30:23];
    big_m   = {big[30:23] != '0, big[22:0]};
    small_m = {lesser[30:23] != '0, lesser[22:0]};
    d       = big_e - small_e;
    small_ext = {small_m, 3'b000};
    if (d >= 8'd27) begin
      sh = '0;
      st = small_m != '0;
    end else begin
      sh = small_ext >> d;
      st = (small_ext & ~({27{1'b1}} << d)) != '0;
    end
    al = {sh[26:1], sh[0] | st};
  end

  always_comb begin
    sum = a_sub_q ? ({1'b0, a_big_q} - {1'b0, a_al_q}) : ({1'b0, a_big_q} + {1'b0, a_al_q});
    lz  = lzc27(sum[26:0]);
    lim = a_e_q - 8'd1;
    shl = ({3'd0, lz} < lim) ? {3'd0, lz} : lim;
    if (sum[27]) begin
      nm = {sum[27:2], sum[1] | sum[0]};
      ne = {1'b0, a_e_q} + 9'd1;
    end else begin
      nm = sum[26:0] << shl;
      ne = {1'b0, a_e_q} - {1'b0, shl};
    end
  end

  always_comb begin
    up = b_m_q[2] && (b_m_q[1] || b_m_q[0] || b_m_q[3]);
    mr = {1'b0, b_m_q[26:3]} + {24'd0, up};
    if (mr[24]) begin
      ef   = {1'b0, b_e_q} + 10'd1;
      frac = mr[23:1];
    end else begin
      ef   = mr[23] ? {1'b0, b_e_q} : 10'd0;
      frac = mr[22:0];
    end
    priority if (b_nan_q) begin
      res = bfa_pkg::FP32_QNAN;
    end else if (b_inf_q) begin
      res = {b_isign_q, 8'hFF, 23'd0};
    end else if (ef >= 10'd255) begin
      res = {b_sign_q, 8'hFF, 23'd0};
    end else begin
      res = {b_sign_q, ef[7:0], frac};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= pop_o;
      b_v_q <= a_v_q;
      o_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sign_q  <= big[31];
      a_sub_q   <= fa[31] ^ fb[31];
      a_nan_q   <= nan_a || nan_b || (inf_a && inf_b && (fa[31] != fb[31]));
      a_inf_q   <= inf_a || inf_b;
      a_isign_q <= inf_a ? fa[31] : fb[31];
      a_last_q  <= item_i.last_elem;
      a_e_q     <= big_e;
      a_big_q   <= {big_m, 3'b000};
      a_al_q    <= al;
      b_sign_q  <= (sum == '0 && a_sub_q) ? 1'b0 : a_sign_q;
      b_nan_q   <= a_nan_q;
      b_inf_q   <= a_inf_q;
      b_isign_q <= a_isign_q;
      b_last_q  <= a_last_q;
      b_e_q     <= ne;
      b_m_q     <= nm;
      o_sum_q   <= res;
      o_last_q  <= b_last_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign sum_value_o = o_sum_q;
  assign last_elem_o = o_last_q;

endmodule

FILE: design/broadcast_float_add_unit.sv
// Top level of the broadcast float add block.
// Depends on bfa_pkg, bfa_front, bfa_queue and bfa_fpadd.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): a load item (req_type 0) writes
//   table_value into the operand table; a stream item (req_type 1) adds
//   full_operand to other_operand, or to the table entry picked by the
//   position counters when broadcast_on is set, and yields one result.
//   Output channel (out_valid_o / out_stall_i): sum_value and last_elem.
//   Configuration (cfg_valid_i / cfg_ready_o): always ready; register index
//   on cfg_index_i, value on cfg_data_i. A write to a known register clears
//   the position counters. Write only while the block is idle.
//   Path from the edge that accepts a stream item to the edge that makes
//   its result valid: five front stages (index reduction by reciprocal
//   multiply, table read), the queue, then three adder stages, the last
//   of them the output register.
//   Throughput: one item per cycle when not stalled; the table memory port
//   is used once per item and the adder takes one operand pair per cycle.
//   Reset clears counters, configuration and all valid bits; table contents
//   are undefined until loaded. A stalled output freezes the adder, the queue
//   fills, and then in_stall_o rises.
`timescale 1ns / 1ps

module broadcast_float_add_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [9:0]  table_index_i,
  input  logic [31:0] table_value_i,
  input  logic [31:0] full_operand_i,
  input  logic [31:0] other_operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sum_value_o,
  output logic        last_elem_o
);

  logic               f_valid, q_full, q_pop, q_ne;
  bfa_pkg::add_item_t f_item, q_head;

  assign cfg_ready_o = 1'b1;

  bfa_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .full_operand_i (full_operand_i),
    .other_operand_i(other_operand_i),
    .item_valid_o   (f_valid),
    .item_o         (f_item),
    .queue_full_i   (q_full)
  );

  bfa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (f_valid),
    .push_item_i(f_item),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .not_empty_o(q_ne),
    .head_o     (q_head)
  );

  bfa_fpadd u_fpadd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_ne),
    .item_i     (q_head),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sum_value_o(sum_value_o),
    .last_elem_o(last_elem_o)
  );

endmodule

FILE: design/bfa_checker.sv
// Port-level checks for broadcast_float_add_unit, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module bfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] sum_value_o,
  input logic        last_elem_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sum_value_o) && $stable(last_elem_o))
    else $error("stalled result changed");

  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sum_value_o[30:23] == 8'hFF) && (sum_value_o[22:0] != 23'd0)
      |-> sum_value_o == 32'h7FC0_0000)
    else $error("non-canonical NaN result");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind broadcast_float_add_unit bfa_checker u_bfa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .sum_value_o(sum_value_o),
  .last_elem_o(last_elem_o)
);

FILE: test/tb_top.sv
// Self-checking testbench for broadcast_float_add_unit: FP32 sums with optional table broadcast.
// Holds its own bit-exact FP32 adder and position counters; depends on bfa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [31:0] sum_value;
    logic        last_elem;
  } sum_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [24:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [9:0]  table_index;
  logic [31:0] table_value;
  logic [31:0] full_operand;
  logic [31:0] other_operand;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] sum_value;
  logic        last_elem;

  logic [31:0] operand_table [1024];
  logic [23:0] inner_count, expand_count, outer_base, elem_count;
  logic        broadcast_on;
  logic [24:0] inner_size, expand_size, total_elems;

  sum_result_t pending_sums[$];
  int          errors = 0;
  int          sums_checked = 0;
  int          loads_sent;
  int          streams_sent;
  int          cfg_writes;
  int          out_hold = 0;
  bit          idle_en;

  broadcast_float_add_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .table_index_i  (table_index),
    .table_value_i  (table_value),
    .full_operand_i (full_operand),
    .other_operand_i(other_operand),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sum_value_o    (sum_value),
    .last_elem_o    (last_elem)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] fp32_sum(logic [31:0] x, logic [31:0] y);
    logic [31:0] a, b;
    logic [27:0] ma, mb, s;
    logic [24:0] m;
    int          ea, eb, d, e;
    logic        rnd;
    if ((x[30:23] == 8'hFF && x[22:0] != 0) || (y[30:23] == 8'hFF && y[22:0] != 0))
      return bfa_pkg::FP32_QNAN;
    if (x[30:23] == 8'hFF) begin
      if (y[30:23] == 8'hFF && x[31] != y[31]) return bfa_pkg::FP32_QNAN;
      return x;
    end
    if (y[30:23] == 8'hFF) return y;
    a = x;
    b = y;
    if (y[30:0] > x[30:0]) begin
      a = y;
      b = x;
    end
    ea = (a[30:23] == 0) ? 1 : a[30:23];
    eb = (b[30:23] == 0) ? 1 : b[30:23];
    ma = {1'b0, a[30:23] != 0, a[22:0], 3'b000};
    mb = {1'b0, b[30:23] != 0, b[22:0], 3'b000};
    d = ea - eb;
    if (d >= 27) mb = (mb != 0) ? 28'd1 : 28'd0;
    else mb = (mb >> d) | ((mb & ((28'd1 << d) - 1)) != 0);
    e = ea;
    if (a[31] == b[31]) begin
      s = ma + mb;
      if (s[27]) begin
        s = (s >> 1) | s[0];
        e++;
      end
    end else begin
      s = ma - mb;
      if (s == 0) return 32'h0;
      while (!s[26] && e > 1) begin
        s = s << 1;
        e--;
      end
    end
    rnd = s[2] && (s[1] || s[0] || s[3]);
    m = s[26:3] + rnd;
    if (m[24]) begin
      m = m >> 1;
      e++;
    end
    if (e >= 255) return {a[31], 8'hFF, 23'h0};
    return {a[31], m[23] ? e[7:0] : 8'h00, m[22:0]};
  endfunction

  function automatic logic [31:0] rand_fp();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
      1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3))};
      2: return {$urandom_range(0, 1) == 1, 8'($urandom_range(120, 134)), 23'($urandom)};
      3: return {$urandom_range(0, 1) == 1, 8'($urandom_range(250, 254)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic void clear_position();
    inner_count  = '0;
    expand_count = '0;
    outer_base   = '0;
    elem_count   = '0;
  endfunction

  function automatic void predict_stream(logic [31:0] full, logic [31:0] other);
    logic [31:0] second;
    logic [23:0] pos;
    sum_result_t r;
    pos = outer_base + inner_count;
    second = broadcast_on ? operand_table[pos[9:0]] : other;
    r.sum_value = fp32_sum(full, second);
    r.last_elem = (32'(elem_count) + 1) >= 32'(total_elems);
    pending_sums.push_back(r);
    if (r.last_elem) begin
      clear_position();
    end else begin
      elem_count++;
      if (32'(inner_count) + 1 >= 32'(inner_size)) begin
        inner_count = '0;
        if (32'(expand_count) + 1 >= 32'(expand_size)) begin
          expand_count = '0;
          outer_base = outer_base + inner_size[23:0];
        end else begin
          expand_count++;
        end
      end else begin
        inner_count++;
      end
    end
  endfunction

  task automatic send_item(logic kind, logic [9:0] idx, logic [31:0] tval,
                           logic [31:0] full, logic [31:0] other);
    int gap;
    req_type      <= kind;
    table_index   <= idx;
    table_value   <= tval;
    full_operand  <= full;
    other_operand <= other;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (kind == bfa_pkg::REQ_LOAD) begin
      operand_table[idx] = tval;
      loads_sent++;
    end else begin
      predict_stream(full, other);
      streams_sent++;
    end
    @(negedge clk);
    gap = idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_sum(logic [31:0] full, logic [31:0] other);
    send_item(bfa_pkg::REQ_STREAM, 10'($urandom), $urandom, full, other);
  endtask

  task automatic send_load(logic [9:0] idx, logic [31:0] tval);
    send_item(bfa_pkg::REQ_LOAD, idx, tval, $urandom, $urandom);
  endtask

  task automatic write_reg(bfa_pkg::cfg_index_e idx, logic [24:0] data);
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bfa_pkg::CFG_BROADCAST_ON: broadcast_on = data[0];
      bfa_pkg::CFG_INNER_SIZE:   inner_size   = data;
      bfa_pkg::CFG_EXPAND_SIZE:  expand_size  = data;
      bfa_pkg::CFG_TOTAL_ELEMS:  total_elems  = data;
      default: ;
    endcase
    clear_position();
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_shape(logic bcast, logic [24:0] inner, logic [24:0] expand,
                           logic [24:0] total);
    write_reg(bfa_pkg::CFG_BROADCAST_ON, {24'h0, bcast});
    write_reg(bfa_pkg::CFG_INNER_SIZE, inner);
    write_reg(bfa_pkg::CFG_EXPAND_SIZE, expand);
    write_reg(bfa_pkg::CFG_TOTAL_ELEMS, total);
  endtask

  task automatic test_fp_corners();
    idle_en = 1'b0;
    send_sum(32'h0000_0000, 32'h8000_0000);
    send_sum(32'h8000_0000, 32'h8000_0000);
    send_sum(32'h7F80_0000, 32'hFF80_0000);
    send_sum(32'h7F80_0000, 32'h3F80_0000);
    send_sum(32'h7FC1_2345, 32'h3F80_0000);
    send_sum(32'h3F80_0000, 32'hFF80_0001);
    send_sum(32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_sum(32'h0000_0001, 32'h8000_0001);
    send_sum(32'h007F_FFFF, 32'h0000_0001);
    send_sum(32'h3F80_0000, 32'hBF80_0000);
    send_sum(32'h3F80_0000, 32'h3380_0000);
    send_sum(32'h3F80_0001, 32'h3380_0000);
    send_sum(32'h3F80_0000, 32'hB300_0001);
    send_sum(32'hFFFF_FFFF, 32'h0000_0000);
    send_sum(32'h4B7F_FFFF, 32'h3F00_0000);
  endtask

  task automatic test_table_fill();
    idle_en = 1'b1;
    for (int i = 0; i < 1024; i++) send_load(10'(i), rand_fp());
  endtask

  task automatic test_broadcast_shapes();
    set_shape(1'b1, 25'd1, 25'd1, 25'd1);
    for (int i = 0; i < 6; i++) send_sum(rand_fp(), $urandom);
    set_shape(1'b1, 25'd4, 25'd3, 25'd24);
    for (int i = 0; i < 50; i++) send_sum(rand_fp(), $urandom);
    set_shape(1'b1, 25'd0, 25'd0, 25'd0);
    for (int i = 0; i < 6; i++) send_sum(rand_fp(), $urandom);
    set_shape(1'b0, 25'd5, 25'd2, 25'd7);
    for (int i = 0; i < 20; i++) send_sum(rand_fp(), rand_fp());
  endtask

  task automatic test_size_extremes();
    set_shape(1'b1, 25'd16777216, 25'd16777216, 25'd16777216);
    for (int i = 0; i < 40; i++) send_sum(rand_fp(), $urandom);
    set_shape(1'b1, 25'd1, 25'd16777216, 25'd16777216);
    for (int i = 0; i < 20; i++) send_sum(rand_fp(), $urandom);
    set_shape(1'b1, 25'd3, 25'd1, 25'd16777216);
    for (int i = 0; i < 40; i++) send_sum(rand_fp(), $urandom);
  endtask

  task automatic test_random_mix();
    int n;
    for (int p = 0; p < 10; p++) begin
      idle_en = (p % 3) != 2;
      set_shape(1'($urandom_range(0, 1)), 25'($urandom_range(0, 8)),
                25'($urandom_range(0, 6)), 25'($urandom_range(0, 60)));
      n = $urandom_range(20, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) send_load(10'($urandom), rand_fp());
        else send_sum(rand_fp(), rand_fp());
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= (out_hold > 0);
  end

  always @(posedge clk) begin
    sum_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      out_hold <= idle_en ? $urandom_range(0, 10) : 0;
      if (pending_sums.size() == 0) begin
        $error("unexpected result: sum_value %h last_elem %b", sum_value, last_elem);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        sums_checked++;
        if (sum_value !== want.sum_value) begin
          $error("sum_value: expected %h, got %h", want.sum_value, sum_value);
          errors++;
        end
        if (last_elem !== want.last_elem) begin
          $error("last_elem: expected %b, got %b", want.last_elem, last_elem);
          errors++;
        end
      end
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = bfa_pkg::REQ_LOAD;
    table_index = '0;
    table_value = '0;
    full_operand = '0;
    other_operand = '0;
    idle_en = 1'b0;
    loads_sent = 0;
    streams_sent = 0;
    cfg_writes = 0;
    broadcast_on = 1'b0;
    inner_size = 25'd1;
    expand_size = 25'd1;
    total_elems = 25'd1;
    clear_position();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_fp_corners();
    test_table_fill();
    test_broadcast_shapes();
    test_size_extremes();
    test_random_mix();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d loads, %0d stream items, %0d register writes; %0d sums checked.",
             loads_sent, streams_sent, cfg_writes, sums_checked);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
design/bfa_pkg.sv
design/bfa_front.sv
design/bfa_queue.sv
design/bfa_fpadd.sv
design/broadcast_float_add_unit.sv
design/bfa_checker.sv
test/tb_top.sv
